// ===== design/midpoint_circle_rasterizer_top_defines.svh =====
// Assertion macros shared by the circle rasterizer modules.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_TOP_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property checked every clock, off while reset is high.
`define MCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle implies consequence in the next.
`define MCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MCR_ASSERT(lbl, prop, msg)
`define MCR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/mcr_pkg.sv =====
// Shared types and constants of the circle rasterizer.
package mcr_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam int POINT_W     = 14;
  localparam int MAX_RESULTS = 8;
  localparam int K_W         = $clog2(MAX_RESULTS);
  localparam logic [K_W-1:0] K_LAST = K_W'(MAX_RESULTS - 1);

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic pt_valid;  // job carries eight real points
    logic done;      // circle finished by this request
  } mcr_job_ctl_t;

  localparam int JOB_CTL_W = $bits(mcr_job_ctl_t);

endpackage

// ===== design/mcr_queue.sv =====
// Small register FIFO between the front and the back.
`include "midpoint_circle_rasterizer_top_defines.svh"
module mcr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign dout    = mem[rd_ptr];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end

  `MCR_ASSERT(a_q_no_push_full, full |-> !push, "queue pushed while full")
  `MCR_ASSERT_NEXT(a_q_drain, do_pop && !do_push, count == $past(count) - CW'(1),
                   "queue count did not drop on pop")

endmodule

// ===== design/mcr_front.sv =====
// Front: takes requests, runs the midpoint recurrence, queues point jobs.
`include "midpoint_circle_rasterizer_top_defines.svh"
module mcr_front import mcr_pkg::*; #(
  parameter  int COORD_BITS = 12,
  localparam int XW = COORD_BITS + 2,
  localparam int DW = COORD_BITS + 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  opcode,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic [COORD_BITS-1:0] radius,
  input  logic                  q_full,
  output logic                  push,
  output mcr_job_ctl_t          job_ctl,
  output logic [COORD_BITS-1:0] job_ox,
  output logic [COORD_BITS-1:0] job_oy,
  output logic signed [XW-1:0]  job_x,
  output logic signed [XW-1:0]  job_y
);

  logic signed [XW-1:0]  offset_x, offset_x_next;
  logic signed [XW-1:0]  offset_y, offset_y_next;
  logic signed [DW-1:0]  decision, decision_next;
  logic [COORD_BITS-1:0] origin_x, origin_x_next;
  logic [COORD_BITS-1:0] origin_y, origin_y_next;
  logic                  running, running_next;
  logic                  accept;

  logic signed [XW-1:0] x_inc;
  logic signed [XW-1:0] y_dec;
  logic signed [DW-1:0] rad_d;
  logic signed [DW-1:0] diff_d;

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;
  assign push      = accept;

  assign x_inc  = offset_x + XW'(1);
  assign y_dec  = offset_y - XW'(1);
  assign rad_d  = signed'(DW'(radius));
  assign diff_d = DW'(x_inc) - DW'(y_dec);

  always_comb begin
    offset_x_next = offset_x;
    offset_y_next = offset_y;
    decision_next = decision;
    origin_x_next = origin_x;
    origin_y_next = origin_y;
    running_next  = running;
    job_ctl       = '{pt_valid: 1'b1, done: 1'b0};
    if (opcode == OP_START) begin
      origin_x_next = center_x;
      origin_y_next = center_y;
      offset_x_next = '0;
      offset_y_next = signed'(XW'(radius));
      decision_next = DW'(1) - rad_d;
      running_next  = 1'b1;
    end else if (!running) begin
      job_ctl = '{pt_valid: 1'b0, done: 1'b1};
    end else begin
      offset_x_next = x_inc;
      if (decision < 0) begin
        decision_next = decision + (DW'(x_inc) <<< 1) + DW'(1);
      end else begin
        offset_y_next = y_dec;
        decision_next = decision + (diff_d <<< 1) + DW'(1);
      end
      running_next = !(offset_x_next > offset_y_next);
      job_ctl      = '{pt_valid: 1'b1, done: !running_next};
    end
  end

  assign job_ox = origin_x_next;
  assign job_oy = origin_y_next;
  assign job_x  = offset_x_next;
  assign job_y  = offset_y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      decision <= '0;
      origin_x <= '0;
      origin_y <= '0;
      running  <= 1'b0;
    end else if (accept) begin
      offset_x <= offset_x_next;
      offset_y <= offset_y_next;
      decision <= decision_next;
      origin_x <= origin_x_next;
      origin_y <= origin_y_next;
      running  <= running_next;
    end
  end

  `MCR_ASSERT(a_front_run_order, running |-> (offset_x <= offset_y),
              "active circle has x past y")

endmodule

// ===== design/mcr_back.sv =====
// Back: expands each queued job into its mirrored points, one per cycle unless the result side stalls.
`include "midpoint_circle_rasterizer_top_defines.svh"
module mcr_back import mcr_pkg::*; #(
  parameter  int COORD_BITS = 12,
  localparam int XW = COORD_BITS + 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      pop,
  input  mcr_job_ctl_t              job_ctl,
  input  logic [COORD_BITS-1:0]     job_ox,
  input  logic [COORD_BITS-1:0]     job_oy,
  input  logic signed [XW-1:0]      job_x,
  input  logic signed [XW-1:0]      job_y,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic signed [POINT_W-1:0] point_x,
  output logic signed [POINT_W-1:0] point_y,
  output logic                      point_valid,
  output logic                      group_last,
  output logic                      circle_done
);

  localparam int SW = (COORD_BITS + 3 > POINT_W) ? COORD_BITS + 3 : POINT_W;

  logic                  busy;
  logic [K_W-1:0]        k;
  mcr_job_ctl_t          cur_ctl;
  logic [COORD_BITS-1:0] cur_ox;
  logic [COORD_BITS-1:0] cur_oy;
  logic signed [XW-1:0]  cur_x;
  logic signed [XW-1:0]  cur_y;

  logic                 emit;
  logic                 last_k;
  logic signed [XW-1:0] a_off;
  logic signed [XW-1:0] b_off;
  logic signed [SW-1:0] ox_s;
  logic signed [SW-1:0] oy_s;
  logic signed [SW-1:0] px_s;
  logic signed [SW-1:0] py_s;

  assign last_k = !cur_ctl.pt_valid || (k == K_LAST);
  assign emit   = busy && (!res_valid || !res_stall);
  assign pop    = q_valid && (!busy || (emit && last_k));

  // k[2] swaps x and y, k[0] negates the x term, k[1] the y term
  assign a_off = k[2] ? cur_y : cur_x;
  assign b_off = k[2] ? cur_x : cur_y;
  assign ox_s  = signed'(SW'(cur_ox));
  assign oy_s  = signed'(SW'(cur_oy));
  assign px_s  = k[0] ? ox_s - SW'(a_off) : ox_s + SW'(a_off);
  assign py_s  = k[1] ? oy_s - SW'(b_off) : oy_s + SW'(b_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      k         <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop)                 busy <= 1'b1;
      else if (emit && last_k) busy <= 1'b0;
      if (emit) k <= last_k ? '0 : k + K_W'(1);
      res_valid <= emit || (res_valid && res_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_ctl <= job_ctl;
      cur_ox  <= job_ox;
      cur_oy  <= job_oy;
      cur_x   <= job_x;
      cur_y   <= job_y;
    end
    if (emit) begin
      point_x     <= cur_ctl.pt_valid ? px_s[POINT_W-1:0] : '0;
      point_y     <= cur_ctl.pt_valid ? py_s[POINT_W-1:0] : '0;
      point_valid <= cur_ctl.pt_valid;
      group_last  <= last_k;
      circle_done <= cur_ctl.done;
    end
  end

  `MCR_ASSERT(a_back_invalid_single, (res_valid && !point_valid) |-> (group_last && circle_done),
              "invalid result not a single closing result")
  `MCR_ASSERT_NEXT(a_back_k_wrap, emit && last_k, k == '0, "point index did not wrap")

endmodule

// ===== design/midpoint_circle_rasterizer_top.sv =====
// Top level of the midpoint circle rasterizer.
//
// Request channel (req_valid / req_stall): opcode START latches center and
// radius and yields the eight mirrored points of (0, radius); opcode STEP
// advances the midpoint recurrence one column and yields eight points, or a
// single result with point_valid low when no circle is active.
// Result channel (res_valid / res_stall): one point per cycle while res_stall
// is low; group_last marks the final result of a request, circle_done the
// step where x > y and every idle STEP. The first result of a request
// passes the queue, the back end's job register and its result register.
// A START or STEP yields eight results and an idle STEP a single one.
// The front updates the recurrence in the acceptance cycle and pushes a job
// into a two-entry queue; req_stall is high only while that queue is full.
// A stalled result holds its output register; the back end then stops, the
// queue fills and the request side stalls.
// Reset (synchronous, active high) clears the recurrence, leaves no circle
// active and empties the queue and the result register.
module midpoint_circle_rasterizer_top import mcr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      opcode,
  input  logic [COORD_BITS-1:0]     center_x,
  input  logic [COORD_BITS-1:0]     center_y,
  input  logic [COORD_BITS-1:0]     radius,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic signed [POINT_W-1:0] point_x,
  output logic signed [POINT_W-1:0] point_y,
  output logic                      point_valid,
  output logic                      group_last,
  output logic                      circle_done
);

  localparam int XW    = COORD_BITS + 2;
  localparam int JOB_W = JOB_CTL_W + 2 * COORD_BITS + 2 * XW;

  // front -> queue
  logic                  push;
  logic                  q_full;
  mcr_job_ctl_t          f_ctl;
  logic [COORD_BITS-1:0] f_ox;
  logic [COORD_BITS-1:0] f_oy;
  logic signed [XW-1:0]  f_x;
  logic signed [XW-1:0]  f_y;

  // queue -> back
  logic                  pop;
  logic                  q_valid;
  logic [JOB_W-1:0]      q_din;
  logic [JOB_W-1:0]      q_dout;
  mcr_job_ctl_t          b_ctl;
  logic [COORD_BITS-1:0] b_ox;
  logic [COORD_BITS-1:0] b_oy;
  logic signed [XW-1:0]  b_x;
  logic signed [XW-1:0]  b_y;

  mcr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .opcode   (opcode),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .q_full   (q_full),
    .push     (push),
    .job_ctl  (f_ctl),
    .job_ox   (f_ox),
    .job_oy   (f_oy),
    .job_x    (f_x),
    .job_y    (f_y)
  );

  assign q_din = {f_ctl, f_ox, f_oy, f_x, f_y};
  assign {b_ctl, b_ox, b_oy, b_x, b_y} = q_dout;

  mcr_queue #(.WIDTH(JOB_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (q_din),
    .full (q_full),
    .pop  (pop),
    .dout (q_dout),
    .valid(q_valid)
  );

  mcr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .pop        (pop),
    .job_ctl    (b_ctl),
    .job_ox     (b_ox),
    .job_oy     (b_oy),
    .job_x      (b_x),
    .job_y      (b_y),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_valid(point_valid),
    .group_last (group_last),
    .circle_done(circle_done)
  );

endmodule
